@@ rtl/nonoverlap_pattern_counter_core_defines.svh @@
// Assertion macros shared by the pattern counter RTL
`ifndef NONOVERLAP_PATTERN_COUNTER_CORE_DEFINES_SVH
`define NONOVERLAP_PATTERN_COUNTER_CORE_DEFINES_SVH

// Same-cycle check, disabled while reset is asserted
`define NPC_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Next-cycle check, disabled while reset is asserted
`define NPC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);

`endif

@@ rtl/npc_pkg.sv @@
// Shared types, constants and helpers for the pattern counter
`default_nettype none
package npc_pkg;

	localparam int PATTERN_MAX_DEF = 8;
	localparam int COUNT_BITS_DEF  = 32;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;

	localparam logic [1:0] REG_PATTERN_BYTES  = 2'd0;
	localparam logic [1:0] REG_PATTERN_LENGTH = 2'd1;
	localparam logic [1:0] REG_IGNORE_CASE    = 2'd2;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       text_last;
	} in_t;

	typedef struct packed {
		logic        match_end;
		logic [31:0] occurrence_count;
		logic        count_final;
	} out_t;

	typedef struct packed {
		logic [63:0] pattern_bytes;
		logic [3:0]  pattern_length;
		logic        ignore_case;
	} cfg_t;

	typedef struct packed {
		logic shift;
		logic clear;
		logic fold;
	} cell_ctl_t;

	function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic fold);
		if (fold && c >= 8'h41 && c <= 8'h5A)
			return c + 8'h20;
		return c;
	endfunction

	function automatic logic [7:0] pat_char(input logic [63:0] bytes, input logic [2:0] idx);
		return bytes[{idx, 3'b000} +: 8];
	endfunction

endpackage
`default_nettype wire

@@ rtl/npc_cfg.sv @@
// APB register block holding pattern, length and case-fold setting
`default_nettype none
module npc_cfg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [npc_pkg::ADDR_W-1:0] paddr,
	input  wire logic [npc_pkg::DATA_W-1:0] pwdata,
	output logic      [npc_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	output npc_pkg::cfg_t                   cfg
);
	import npc_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[ADDR_W-1:3];
	assign wr_en   = psel && penable && pwrite && pready;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_PATTERN_BYTES:  cfg_q.pattern_bytes  <= pwdata;
				REG_PATTERN_LENGTH: cfg_q.pattern_length <= pwdata[3:0];
				REG_IGNORE_CASE:    cfg_q.ignore_case    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PATTERN_BYTES:  prdata = cfg_q.pattern_bytes;
			REG_PATTERN_LENGTH: prdata = {60'd0, cfg_q.pattern_length};
			REG_IGNORE_CASE:    prdata = {63'd0, cfg_q.ignore_case};
			default:            prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/npc_cell.sv @@
// One window cell: holds a past text byte and compares it to its pattern byte
`default_nettype none
module npc_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire npc_pkg::cell_ctl_t  ctl,
	input  wire logic [7:0]          byte_in,
	input  wire logic [7:0]          pat_byte,
	input  wire logic                in_use,
	output logic      [7:0]          byte_out,
	output logic                     ok
);
	import npc_pkg::*;

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctl.shift) begin
			byte_q <= ctl.clear ? 8'd0 : byte_in;
		end
	end

	assign byte_out = byte_q;
	// a cell beyond the pattern length does not take part
	assign ok = !in_use || (fold_byte(byte_q, ctl.fold) == fold_byte(pat_byte, ctl.fold));

endmodule
`default_nettype wire

@@ rtl/nonoverlap_pattern_counter_core.sv @@
// Top level: non-overlapping pattern occurrence counter over a byte stream
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+---------------------------
//  in      | in  | in_valid / in_ready        | in_data  (text_byte, last)
//  out     | out | out_valid / out_ready      | out_data (match, count, final)
//  cfg     | in  | psel / penable / pready    | paddr, pwdata, prdata
//
// One byte per cycle sustained while results are taken; each byte's result is set by
// the single compare stage across the window cells and is valid the cycle after acceptance.
// A new byte enters in the same cycle the waiting result is taken.
// Reset clears the window, counters and registers; no clearing pass.
// A stalled output holds its result and drops in_ready until it is taken.
`default_nettype none
module nonoverlap_pattern_counter_core #(
	parameter int PATTERN_MAX = npc_pkg::PATTERN_MAX_DEF,
	parameter int COUNT_BITS  = npc_pkg::COUNT_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire npc_pkg::in_t               in_data,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output npc_pkg::out_t                   out_data,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [npc_pkg::ADDR_W-1:0] paddr,
	input  wire logic [npc_pkg::DATA_W-1:0] pwdata,
	output logic      [npc_pkg::DATA_W-1:0] prdata,
	output logic                            pready
);
	import npc_pkg::*;

	`include "nonoverlap_pattern_counter_core_defines.svh"

	localparam int WIN    = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
	localparam int SEEN_W = $clog2(PATTERN_MAX + 1);
	localparam int SKIP_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int CNT_W  = (COUNT_BITS < 32) ? COUNT_BITS : 32;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [3:0] LEN_MAX = 4'(PATTERN_MAX);

	cfg_t      cfg;
	cell_ctl_t cell_ctl;

	logic [SEEN_W-1:0] seen_q, seen_nxt;
	logic [SKIP_W-1:0] skip_q, skip_nxt;
	logic [CNT_W-1:0]  cnt_q, cnt_nxt;
	logic              out_valid_q;
	out_t              out_q;

	logic [3:0]     eff_len;
	logic           in_fire;
	logic           seen_ok;
	logic           cur_ok;
	logic           hit;
	logic [WIN-1:0] cell_ok;
	logic [7:0]     cell_byte [WIN];
	logic [3:0]     last_idx;
	logic           last_fire;
	logic           step_fire;
	logic           text_idle;

	npc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign eff_len  = (cfg.pattern_length > LEN_MAX) ? LEN_MAX : cfg.pattern_length;
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	assign cell_ctl.shift = in_fire;
	assign cell_ctl.clear = in_data.text_last;
	assign cell_ctl.fold  = cfg.ignore_case;

	// cell i holds the byte i+1 positions back and checks pattern byte len-2-i
	for (genvar i = 0; i < WIN; i++) begin : g_cell
		logic [7:0] byte_in;
		logic [3:0] pidx;
		logic       in_use;

		if (i == 0) begin : g_head
			assign byte_in = in_data.text_byte;
		end else begin : g_link
			assign byte_in = cell_byte[i-1];
		end
		assign pidx   = eff_len - 4'd2 - 4'(i);
		assign in_use = (4'(i) + 4'd2) <= eff_len;

		npc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (cell_ctl),
			.byte_in  (byte_in),
			.pat_byte (pat_char(cfg.pattern_bytes, pidx[2:0])),
			.in_use   (in_use),
			.byte_out (cell_byte[i]),
			.ok       (cell_ok[i])
		);
	end

	assign last_idx = eff_len - 4'd1;
	assign cur_ok   = fold_byte(in_data.text_byte, cfg.ignore_case)
		== fold_byte(pat_char(cfg.pattern_bytes, last_idx[2:0]), cfg.ignore_case);
	assign seen_ok  = (5'(seen_q) + 5'd1) >= {1'b0, eff_len};
	assign hit      = (eff_len != 4'd0) && (skip_q == '0) && seen_ok && cur_ok && (&cell_ok);

	always_comb begin
		cnt_nxt = cnt_q;
		if (hit && cnt_q != CNT_MAX)
			cnt_nxt = cnt_q + 1'b1;
		skip_nxt = skip_q;
		if (hit)
			skip_nxt = SKIP_W'(last_idx);
		else if (skip_q != '0)
			skip_nxt = skip_q - 1'b1;
		seen_nxt = seen_q;
		if (seen_q < SEEN_W'(PATTERN_MAX))
			seen_nxt = seen_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			skip_q <= '0;
			cnt_q  <= '0;
		end else if (in_fire) begin
			// drop per-text state once the last byte goes through
			if (in_data.text_last) begin
				seen_q <= '0;
				skip_q <= '0;
				cnt_q  <= '0;
			end else begin
				seen_q <= seen_nxt;
				skip_q <= skip_nxt;
				cnt_q  <= cnt_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_q.match_end        <= hit;
			out_q.occurrence_count <= 32'(cnt_nxt);
			out_q.count_final      <= in_data.text_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign last_fire = in_fire && in_data.text_last;
	assign step_fire = in_fire && hit && !in_data.text_last && (cnt_q != CNT_MAX);
	assign text_idle = (cnt_q == '0) && (seen_q == '0) && (skip_q == '0);

	`NPC_ASSERT(a_skip_blocks_hit, (skip_q != '0) |-> !hit, "match inside skip span")
	`NPC_ASSERT(a_ready_when_empty, !out_valid_q |-> in_ready, "stalled with empty output")
	`NPC_ASSERT_NEXT(a_clear_on_last, last_fire, text_idle, "text state not cleared")
	`NPC_ASSERT_NEXT(a_count_step, step_fire, (cnt_q == $past(cnt_q) + 1'b1), "no count step")

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the non-overlapping pattern occurrence counter
module tb_top;
	import npc_pkg::*;

	localparam int WINDOW_DEPTH = PATTERN_MAX_DEF - 1;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	in_t               in_data;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_t              out_data;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// Predictor copy of the registers and the per-text scan state
	logic [63:0] m_pattern;
	logic [3:0]  m_length;
	logic        m_fold;
	logic [7:0]  m_window [WINDOW_DEPTH];
	int          m_seen;
	int          m_skip;
	logic [31:0] m_total;

	out_t pending_counts [$];
	out_t head;
	int   err_count;
	bit   in_quiet;
	bit   out_quiet;
	int   out_stall = 0;

	nonoverlap_pattern_counter_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic int eff_len();
		return (m_length > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(m_length);
	endfunction

	function automatic logic [7:0] to_lower(logic [7:0] c);
		if (m_fold && c >= 8'h41 && c <= 8'h5A)
			return c | 8'h20;
		return c;
	endfunction

	function automatic void clear_text();
		for (int k = 0; k < WINDOW_DEPTH; k++)
			m_window[k] = 8'h00;
		m_seen = 0;
		m_skip = 0;
		m_total = '0;
	endfunction

	// Scan one byte against the window and return the count it produces
	function automatic out_t advance_count(in_t b);
		out_t r;
		int len;
		int k;
		bit hit;
		logic [7:0] tc;
		len = eff_len();
		hit = 1'b0;
		if (len > 0 && m_skip == 0 && m_seen + 1 >= len) begin
			hit = 1'b1;
			for (k = 0; k < len; k++) begin
				if (k == 0)
					tc = b.text_byte;
				else
					tc = m_window[k - 1];
				if (to_lower(m_pattern[(len - 1 - k) * 8 +: 8]) != to_lower(tc))
					hit = 1'b0;
			end
		end
		if (hit) begin
			if (m_total != '1)
				m_total++;
			m_skip = (len - 1) & 7;
		end else if (m_skip > 0) begin
			m_skip--;
		end
		for (k = WINDOW_DEPTH - 1; k > 0; k--)
			m_window[k] = m_window[k - 1];
		m_window[0] = b.text_byte;
		if (m_seen < PATTERN_MAX_DEF)
			m_seen++;
		r.match_end = hit;
		r.occurrence_count = m_total;
		r.count_final = b.text_last;
		if (b.text_last)
			clear_text();
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		err_count++;
		if (err_count <= 40)
			$display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
	endtask

	always @(negedge clk) begin
		if (out_stall > 0) begin
			out_ready <= 1'b0;
			out_stall = out_stall - 1;
		end else begin
			out_ready <= 1'b1;
			if (!out_quiet)
				out_stall = idle_len();
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_counts.size() == 0) begin
				report_mismatch("result with nothing pending", out_data, 0);
			end else begin
				head = pending_counts.pop_front();
				if (out_data.match_end !== head.match_end)
					report_mismatch("match_end", out_data.match_end, head.match_end);
				if (out_data.occurrence_count !== head.occurrence_count)
					report_mismatch("occurrence_count", out_data.occurrence_count,
						head.occurrence_count);
				if (out_data.count_final !== head.count_final)
					report_mismatch("count_final", out_data.count_final, head.count_final);
			end
		end
	end

	task automatic send_byte(logic [7:0] c, bit last);
		int gap;
		gap = in_quiet ? 0 : idle_len();
		if (gap > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data.text_byte <= c;
		in_data.text_last <= last;
		do @(posedge clk); while (!in_ready);
		pending_counts.push_back(advance_count(in_data));
	endtask

	task automatic send_text(string s, bit close);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], close && i == s.len() - 1);
	endtask

	// Drop valid and hold until every pending count has come back
	task automatic drain();
		@(negedge clk) in_valid <= 1'b0;
		while (pending_counts.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic apb_cycle(bit wr, logic [1:0] idx, logic [63:0] val,
		output logic [63:0] rd);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [63:0] val);
		logic [63:0] unused;
		apb_cycle(1'b1, idx, val, unused);
		case (idx)
			REG_PATTERN_BYTES:  m_pattern = val;
			REG_PATTERN_LENGTH: m_length = val[3:0];
			REG_IGNORE_CASE:    m_fold = val[0];
			default: ;
		endcase
	endtask

	task automatic check_reg(logic [1:0] idx);
		logic [63:0] rd;
		apb_cycle(1'b0, idx, 64'h0, rd);
		case (idx)
			REG_PATTERN_BYTES:
				if (rd !== m_pattern)
					report_mismatch("pattern_bytes readback", rd, m_pattern);
			REG_PATTERN_LENGTH:
				if (rd[3:0] !== m_length)
					report_mismatch("pattern_length readback", rd[3:0], m_length);
			REG_IGNORE_CASE:
				if (rd[0] !== m_fold)
					report_mismatch("ignore_case readback", rd[0], m_fold);
			default: ;
		endcase
	endtask

	function automatic logic [7:0] base_char();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h62) ^
				(($urandom_range(0, 1) != 0) ? 8'h20 : 8'h00);
		if (r < 9) begin
			case ($urandom_range(0, 7))
				0: return 8'h40;
				1: return 8'h41;
				2: return 8'h5A;
				3: return 8'h5B;
				4: return 8'h60;
				5: return 8'h61;
				6: return 8'h7A;
				default: return 8'h7B;
			endcase
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// Flip the case of a letter now and then when folding is on
	function automatic logic [7:0] case_noise(logic [7:0] c);
		if (m_fold && (c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A &&
			$urandom_range(0, 1) != 0)
			return c ^ 8'h20;
		return c;
	endfunction

	function automatic logic [7:0] text_char();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5 && eff_len() > 0)
			return case_noise(m_pattern[$urandom_range(0, eff_len() - 1) * 8 +: 8]);
		if (r < 8)
			return base_char();
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic random_config();
		logic [63:0] pat;
		int r;
		if ($urandom_range(0, 4) == 0) begin
			pat = {$urandom, $urandom};
		end else begin
			for (int k = 0; k < 8; k++)
				pat[k * 8 +: 8] = base_char();
		end
		write_reg(REG_PATTERN_BYTES, pat);
		r = $urandom_range(0, 19);
		if (r == 0)
			write_reg(REG_PATTERN_LENGTH, 64'd0);
		else if (r == 1)
			write_reg(REG_PATTERN_LENGTH, 64'($urandom_range(9, 15)));
		else if (r < 5)
			write_reg(REG_PATTERN_LENGTH, 64'd8);
		else
			write_reg(REG_PATTERN_LENGTH, 64'($urandom_range(1, 7)));
		write_reg(REG_IGNORE_CASE, 64'($urandom_range(0, 1)));
	endtask

	task automatic test_empty_pattern();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		drain();
	endtask

	task automatic test_registers();
		write_reg(REG_PATTERN_BYTES, '1);
		write_reg(REG_PATTERN_LENGTH, 64'd15);
		write_reg(REG_IGNORE_CASE, 64'd1);
		check_reg(REG_PATTERN_BYTES);
		check_reg(REG_PATTERN_LENGTH);
		check_reg(REG_IGNORE_CASE);
		write_reg(REG_PATTERN_BYTES, 64'h0);
		write_reg(REG_PATTERN_LENGTH, 64'd0);
		write_reg(REG_IGNORE_CASE, 64'd0);
		check_reg(REG_PATTERN_BYTES);
		check_reg(REG_PATTERN_LENGTH);
		check_reg(REG_IGNORE_CASE);
	endtask

	// "aa" over "aaaaa": two counts, the overlapping ones skipped
	task automatic test_nonoverlap();
		write_reg(REG_PATTERN_BYTES, 64'h6161);
		write_reg(REG_PATTERN_LENGTH, 64'd2);
		send_text("aaaaa", 1'b1);
		drain();
	endtask

	// Only A-Z fold; then turn folding off in the middle of a text
	task automatic test_case_fold();
		write_reg(REG_PATTERN_BYTES, 64'h406241);
		write_reg(REG_PATTERN_LENGTH, 64'd3);
		write_reg(REG_IGNORE_CASE, 64'd1);
		send_text("aB`aB@", 1'b0);
		drain();
		write_reg(REG_IGNORE_CASE, 64'd0);
		send_text("AB@", 1'b1);
		drain();
	endtask

	task automatic test_overlong_length();
		write_reg(REG_PATTERN_BYTES, 64'hFF00FF00FF00FF00);
		write_reg(REG_PATTERN_LENGTH, 64'd15);
		for (int i = 0; i < 8; i++)
			send_byte((i % 2 != 0) ? 8'hFF : 8'h00, i == 7);
		drain();
	endtask

	task automatic test_random_texts(int budget);
		int sent;
		int phase_end;
		int tlen;
		int i;
		int n;
		logic [7:0] c;
		sent = 0;
		while (sent < budget) begin
			drain();
			in_quiet = ($urandom_range(0, 3) == 0);
			out_quiet = ($urandom_range(0, 3) == 0);
			random_config();
			phase_end = sent + $urandom_range(60, 200);
			// A phase may stop mid-text, so the next config lands inside that text
			while (sent < phase_end && sent < budget) begin
				tlen = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) :
					$urandom_range(1, 24);
				i = 0;
				while (i < tlen && sent < phase_end) begin
					if ($urandom_range(0, 9) < 4 && eff_len() > 0) begin
						for (n = 0; n < eff_len() && i < tlen; n++) begin
							c = case_noise(m_pattern[n * 8 +: 8]);
							if ($urandom_range(0, 15) == 0)
								c = base_char();
							send_byte(c, i == tlen - 1);
							i++;
							sent++;
						end
					end else begin
						send_byte(text_char(), i == tlen - 1);
						i++;
						sent++;
					end
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		err_count = 0;
		in_quiet = 1'b0;
		out_quiet = 1'b0;
		m_pattern = '0;
		m_length = '0;
		m_fold = 1'b0;
		clear_text();
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_empty_pattern();
		test_registers();
		test_nonoverlap();
		test_case_fold();
		test_overlong_length();
		test_random_texts(1925);
		drain();

		if (err_count == 0 && pending_counts.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/npc_pkg.sv
rtl/npc_cfg.sv
rtl/npc_cell.sv
rtl/nonoverlap_pattern_counter_core.sv
tb/tb_top.sv
